FILE: rtl/linear_softmax_image_classifier_unit_macros.svh
// Assertion macros for the classifier RTL.
// Included by lsic_back, the module that carries concurrent checks; needs no package.
`ifndef LINEAR_SOFTMAX_IMAGE_CLASSIFIER_UNIT_MACROS_SVH
`define LINEAR_SOFTMAX_IMAGE_CLASSIFIER_UNIT_MACROS_SVH

`ifndef SYNTH
`define LSIC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
`define LSIC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `LSIC_ASSERT(lbl, clk, rst_n, !(cond), msg)
`else
`define LSIC_ASSERT(lbl, clk, rst_n, prop, msg)
`define LSIC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

FILE: rtl/lsic_pkg.sv
// Types, constants and queue depths for the linear image classifier.
// No dependencies; imported by every module of the block.
`default_nettype none

package lsic_pkg;

  localparam int unsigned LSIC_MAX_PIXELS  = 16384;
  localparam int unsigned LSIC_NUM_CLASSES = 3;
  localparam int unsigned LSIC_WEIGHT_BITS = 16;

  localparam int unsigned ACC_W     = 48;
  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned OUT_DEPTH = 16;
  localparam int unsigned CMD_PW    = $clog2(CMD_DEPTH);
  localparam int unsigned CMD_CW    = $clog2(CMD_DEPTH + 1);
  localparam int unsigned OUT_PW    = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CW    = $clog2(OUT_DEPTH + 1);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_PIXEL = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    logic               opcode;
    logic [1:0]         weight_class;
    logic [13:0]        weight_address;
    logic signed [15:0] weight_value;
    logic [7:0]         pixel_value;
    logic               last_pixel;
  } lsic_in_t;

  typedef struct packed {
    logic [1:0]          best_class;
    logic signed [47:0]  best_score;
    logic [14:0]         pixels_seen;
  } lsic_out_t;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [1:0]         cls;
    logic [13:0]        addr;
    logic signed [15:0] wval;
    logic [7:0]         pix;
    logic               last;
  } cmd_t;

  // Per-lane controls driven by the back end.
  typedef struct packed {
    logic wr;
    logic rd;
    logic acc;
    logic add;
    logic clr;
  } lane_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/linear_softmax_image_classifier_unit.sv
// Top level of the linear image classifier: front queue plus back end.
// Depends on lsic_pkg, lsic_front and lsic_back.
//
//   channel   | handshake                  | payload
//   ----------+----------------------------+---------------------------
//   request   | push (in), full (out)      | in_item_i  (lsic_in_t)
//   result    | empty (out), pop (in)      | out_item_o (lsic_out_t)
//
// One request per cycle is taken while the command queue has room; weight
// writes and pixels each use the back end's lane memory port.
// A frame-end result passes through the weight read, multiply, accumulate,
// argmax tree level and result queue registers after the pixel enters.
// Frame ends stall only when every result queue slot is reserved by a result in flight or unread.
// Reset clears counters, accumulators and queues; the weight memory is kept.
`default_nettype none

module linear_softmax_image_classifier_unit
  import lsic_pkg::*;
#(
  parameter int unsigned MAX_PIXELS  = LSIC_MAX_PIXELS,
  parameter int unsigned NUM_CLASSES = LSIC_NUM_CLASSES,
  parameter int unsigned WEIGHT_BITS = LSIC_WEIGHT_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  lsic_in_t  in_item_i,
  output logic      empty,
  input  logic      pop,
  output lsic_out_t out_item_o
);

  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  lsic_front #(
    .MAX_PIXELS  (MAX_PIXELS),
    .NUM_CLASSES (NUM_CLASSES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .in_item_i   (in_item_i),
    .full_o      (full),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  lsic_back #(
    .MAX_PIXELS  (MAX_PIXELS),
    .NUM_CLASSES (NUM_CLASSES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

FILE: rtl/lsic_front.sv
// Front end: accepts requests, drops out-of-range weight writes, queues commands.
// Depends on lsic_pkg.
`default_nettype none

module lsic_front
  import lsic_pkg::*;
#(
  parameter int unsigned MAX_PIXELS  = LSIC_MAX_PIXELS,
  parameter int unsigned NUM_CLASSES = LSIC_NUM_CLASSES
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  lsic_in_t in_item_i,
  output logic     full_o,
  output logic     cmd_valid_o,
  output cmd_t     cmd_o,
  input  logic     cmd_pop_i
);

  cmd_t              mem_q [CMD_DEPTH];
  logic [CMD_PW-1:0] wp_q, rp_q;
  logic [CMD_CW-1:0] cnt_q, cnt_d;
  logic              accept, keep, enq, deq;
  cmd_t              cmd_new;

  assign full_o      = (cnt_q == CMD_CW'(CMD_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = mem_q[rp_q];
  assign accept      = push_i & ~full_o;

  always_comb begin
    keep = (in_item_i.opcode == OP_PIXEL) ||
           ((32'(in_item_i.weight_class) < NUM_CLASSES) &&
            (32'(in_item_i.weight_address) < MAX_PIXELS));
    cmd_new.kind = (in_item_i.opcode == OP_PIXEL) ? CMD_PIXEL : CMD_WRITE;
    cmd_new.cls  = in_item_i.weight_class;
    cmd_new.addr = in_item_i.weight_address;
    cmd_new.wval = in_item_i.weight_value;
    cmd_new.pix  = in_item_i.pixel_value;
    cmd_new.last = in_item_i.last_pixel;
  end

  assign enq = accept & keep;
  assign deq = cmd_pop_i & cmd_valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (enq && !deq) begin
      cnt_d = cnt_q + 1'b1;
    end else if (deq && !enq) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (enq) begin
        wp_q <= wp_q + 1'b1;
      end
      if (deq) begin
        rp_q <= rp_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      mem_q[wp_q] <= cmd_new;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lsic_lane.sv
// One class lane: weight memory, pixel multiplier and score accumulator.
// Depends on lsic_pkg.
`default_nettype none

module lsic_lane
  import lsic_pkg::*;
#(
  parameter int unsigned MAX_PIXELS  = LSIC_MAX_PIXELS,
  parameter int unsigned WEIGHT_BITS = LSIC_WEIGHT_BITS,
  localparam int unsigned AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lane_ctl_t               ctl_i,
  input  logic [AW-1:0]           waddr_i,
  input  logic signed [15:0]      wval_i,
  input  logic [AW-1:0]           raddr_i,
  input  logic [7:0]              pix_i,
  output logic signed [ACC_W-1:0] snap_o
);

  localparam int unsigned PW = WEIGHT_BITS + 9;

  logic signed [WEIGHT_BITS-1:0] mem [MAX_PIXELS];
  logic signed [WEIGHT_BITS-1:0] rdata_q;
  logic signed [31:0]            wval32;
  logic signed [PW-1:0]          prod_q;
  logic signed [ACC_W-1:0]       acc_q, snap_q, sum;

  // Sign extend, then keep the stored width.
  assign wval32 = 32'(wval_i);

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      mem[waddr_i] <= wval32[WEIGHT_BITS-1:0];
    end
    if (ctl_i.rd) begin
      rdata_q <= mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= $signed({1'b0, pix_i}) * rdata_q;
  end

  assign sum = ctl_i.add ? acc_q + ACC_W'(prod_q) : acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctl_i.acc) begin
      acc_q <= ctl_i.clr ? '0 : sum;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.acc && ctl_i.clr) begin
      snap_q <= sum;
    end
  end

  assign snap_o = snap_q;

endmodule

`default_nettype wire

FILE: rtl/lsic_argmax.sv
// Registered pairwise argmax tree over the class scores; lower index wins ties.
// Depends on lsic_pkg.
`default_nettype none

module lsic_argmax
  import lsic_pkg::*;
#(
  parameter int unsigned NUM_CLASSES = LSIC_NUM_CLASSES,
  parameter int unsigned TW          = 1,
  localparam int unsigned L = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    vld_i,
  input  logic signed [ACC_W-1:0] scores_i [NUM_CLASSES],
  input  logic [TW-1:0]           tag_i,
  output logic                    vld_o,
  output logic [L-1:0]            idx_o,
  output logic signed [ACC_W-1:0] score_o,
  output logic [TW-1:0]           tag_o
);

  localparam int unsigned N2 = 1 << L;

  // Level lv compares the entries of *_in[lv] and registers them into *_q[lv].
  logic [L-1:0]            vld_in;
  logic [TW-1:0]           tag_in [L];
  logic                    ok_in  [L][N2];
  logic signed [ACC_W-1:0] sc_in  [L][N2];
  logic [L-1:0]            ix_in  [L][N2];

  logic [L-1:0]            vld_q;
  logic [TW-1:0]           tag_q [L];
  logic                    ok_q  [L][N2];
  logic signed [ACC_W-1:0] sc_q  [L][N2];
  logic [L-1:0]            ix_q  [L][N2];

  always_comb begin
    vld_in[0] = vld_i;
    tag_in[0] = tag_i;
    for (int j = 0; j < N2; j++) begin
      ok_in[0][j] = (j < NUM_CLASSES);
      sc_in[0][j] = (j < NUM_CLASSES) ? scores_i[j % NUM_CLASSES] : '0;
      ix_in[0][j] = L'(j);
    end
    for (int lv = 1; lv < L; lv++) begin
      vld_in[lv] = vld_q[lv-1];
      tag_in[lv] = tag_q[lv-1];
      for (int j = 0; j < N2; j++) begin
        ok_in[lv][j] = ok_q[lv-1][j];
        sc_in[lv][j] = sc_q[lv-1][j];
        ix_in[lv][j] = ix_q[lv-1][j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_in;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int lv = 0; lv < L; lv++) begin
      tag_q[lv] <= tag_in[lv];
      for (int j = 0; j < N2 / 2; j++) begin
        // Left keeps the lower indices, so it wins on equal scores.
        if (ok_in[lv][2*j] &&
            (!ok_in[lv][2*j+1] || (sc_in[lv][2*j] >= sc_in[lv][2*j+1]))) begin
          ok_q[lv][j] <= ok_in[lv][2*j];
          sc_q[lv][j] <= sc_in[lv][2*j];
          ix_q[lv][j] <= ix_in[lv][2*j];
        end else begin
          ok_q[lv][j] <= ok_in[lv][2*j+1];
          sc_q[lv][j] <= sc_in[lv][2*j+1];
          ix_q[lv][j] <= ix_in[lv][2*j+1];
        end
      end
      for (int j = N2 / 2; j < N2; j++) begin
        ok_q[lv][j] <= 1'b0;
        sc_q[lv][j] <= '0;
        ix_q[lv][j] <= '0;
      end
    end
  end

  assign vld_o   = vld_q[L-1];
  assign idx_o   = ix_q[L-1][0];
  assign score_o = sc_q[L-1][0];
  assign tag_o   = tag_q[L-1];

endmodule

`default_nettype wire

FILE: rtl/lsic_back.sv
// Back end: pixel counter, issue control, class lanes, argmax and result queue.
// Depends on lsic_pkg, lsic_lane, lsic_argmax and the assertion macro header.
`default_nettype none
`include "linear_softmax_image_classifier_unit_macros.svh"

module lsic_back
  import lsic_pkg::*;
#(
  parameter int unsigned MAX_PIXELS  = LSIC_MAX_PIXELS,
  parameter int unsigned NUM_CLASSES = LSIC_NUM_CLASSES,
  parameter int unsigned WEIGHT_BITS = LSIC_WEIGHT_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  output logic      empty,
  input  logic      pop,
  output lsic_out_t out_item_o
);

  localparam int unsigned AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int unsigned CW = $clog2(MAX_PIXELS + 1);
  localparam int unsigned L  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

  logic              issue, is_px, is_last, add_en, pop_fire;
  logic [CW-1:0]     pos_q, pos_d, cnt_next;
  logic [OUT_CW-1:0] credit_q, credit_d;
  logic [31:0]       addr32;

  logic              s1_vld_q, s1_last_q, s1_add_q;
  logic [7:0]        s1_pix_q;
  logic [CW-1:0]     s1_cnt_q;
  logic              s2_vld_q, s2_last_q, s2_add_q;
  logic [CW-1:0]     s2_cnt_q;
  logic              s3_vld_q;
  logic [CW-1:0]     s3_cnt_q;

  logic signed [ACC_W-1:0] snap [NUM_CLASSES];
  logic                    am_vld;
  logic [L-1:0]            am_idx;
  logic signed [ACC_W-1:0] am_score;
  logic [CW-1:0]           am_cnt;
  logic [31:0]             idx32, cnt32;

  lsic_out_t         oq_q [OUT_DEPTH];
  lsic_out_t         res;
  logic [OUT_PW-1:0] owp_q, orp_q;
  logic [OUT_CW-1:0] ocnt_q;

  assign is_px   = (cmd_i.kind == CMD_PIXEL);
  assign is_last = is_px & cmd_i.last;
  // Hold a frame end until the result queue has a slot reserved for it.
  assign issue     = cmd_valid_i & (~is_last | (credit_q != '0));
  assign cmd_pop_o = issue;

  assign add_en   = (32'(pos_q) < MAX_PIXELS);
  assign cnt_next = add_en ? pos_q + 1'b1 : pos_q;
  assign addr32   = 32'(cmd_i.addr);
  assign pop_fire = pop & ~empty;

  always_comb begin
    pos_d = pos_q;
    if (issue && is_px) begin
      pos_d = is_last ? '0 : cnt_next;
    end
    credit_d = credit_q;
    if (issue && is_last && !pop_fire) begin
      credit_d = credit_q - 1'b1;
    end else if (pop_fire && !(issue && is_last)) begin
      credit_d = credit_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      credit_q <= OUT_CW'(OUT_DEPTH);
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      credit_q <= credit_d;
      s1_vld_q <= issue & is_px;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q & s2_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_last_q <= is_last;
    s1_add_q  <= add_en;
    s1_pix_q  <= cmd_i.pix;
    s1_cnt_q  <= cnt_next;
    s2_last_q <= s1_last_q;
    s2_add_q  <= s1_add_q;
    s2_cnt_q  <= s1_cnt_q;
    s3_cnt_q  <= s2_cnt_q;
  end

  for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_lane
    lane_ctl_t ctl;

    always_comb begin
      ctl.wr  = issue & ~is_px & (32'(cmd_i.cls) == c);
      ctl.rd  = issue & is_px;
      ctl.acc = s2_vld_q;
      ctl.add = s2_add_q;
      ctl.clr = s2_last_q;
    end

    lsic_lane #(
      .MAX_PIXELS  (MAX_PIXELS),
      .WEIGHT_BITS (WEIGHT_BITS)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .waddr_i (addr32[AW-1:0]),
      .wval_i  (cmd_i.wval),
      .raddr_i (pos_q[AW-1:0]),
      .pix_i   (s1_pix_q),
      .snap_o  (snap[c])
    );
  end

  lsic_argmax #(
    .NUM_CLASSES (NUM_CLASSES),
    .TW          (CW)
  ) u_argmax (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (s3_vld_q),
    .scores_i (snap),
    .tag_i    (s3_cnt_q),
    .vld_o    (am_vld),
    .idx_o    (am_idx),
    .score_o  (am_score),
    .tag_o    (am_cnt)
  );

  assign idx32 = 32'(am_idx);
  assign cnt32 = 32'(am_cnt);

  always_comb begin
    res.best_class  = idx32[1:0];
    res.best_score  = am_score;
    res.pixels_seen = cnt32[14:0];
  end

  // Result queue; credits guarantee a free slot for every result in flight.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owp_q  <= '0;
      orp_q  <= '0;
      ocnt_q <= '0;
    end else begin
      if (am_vld) begin
        owp_q <= owp_q + 1'b1;
      end
      if (pop_fire) begin
        orp_q <= orp_q + 1'b1;
      end
      if (am_vld && !pop_fire) begin
        ocnt_q <= ocnt_q + 1'b1;
      end else if (pop_fire && !am_vld) begin
        ocnt_q <= ocnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (am_vld) begin
      oq_q[owp_q] <= res;
    end
  end

  assign empty      = (ocnt_q == '0);
  assign out_item_o = oq_q[orp_q];

  `LSIC_ASSERT(a_credit_bound, clk_i, rst_ni, (32'(credit_q) + 32'(ocnt_q)) <= OUT_DEPTH, "credit and queue fill exceed queue depth")
  `LSIC_ASSERT(a_no_oq_overflow, clk_i, rst_ni, am_vld |-> (32'(ocnt_q) < OUT_DEPTH), "result written into a full queue")
  `LSIC_ASSERT(a_pos_bound, clk_i, rst_ni, 32'(pos_q) <= MAX_PIXELS, "pixel counter beyond limit")
  `LSIC_ASSERT(a_last_clears, clk_i, rst_ni, (issue && is_last) |=> (pos_q == '0), "frame end did not clear the counter")
  `LSIC_ASSERT_NEVER(a_last_no_credit, clk_i, rst_ni, issue && is_last && (credit_q == '0), "frame end issued without a credit")

endmodule

`default_nettype wire
